/* rtl/lri_pkg.sv */
`timescale 1ns / 1ps
package lri_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic emit;
  } lri_cmd_t;

  typedef struct packed {
    logic busy;
    logic span_zero;
  } lri_sts_t;

endpackage

/* rtl/lri_ctrl.sv */
`timescale 1ns / 1ps
module lri_ctrl import lri_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     opcode_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lri_cmd_t cmd_o,
  input  lri_sts_t sts_i
);

  localparam int unsigned CntW = (COORD_BITS > 1) ? $clog2(COORD_BITS) : 1;

  typedef enum logic [2:0] {
    IDLE,
    MUL_LO,
    MUL_HI,
    DIVIDE,
    EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              slot_free;

  assign in_ready_o = (state_q == IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      IDLE: begin
        if (accept) begin
          if (opcode_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (sts_i.busy) begin
            state_d = sts_i.span_zero ? EMIT : MUL_LO;
          end
        end
      end
      MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = MUL_HI;
      end
      MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        cnt_d        = CntW'(COORD_BITS - 1);
        state_d      = DIVIDE;
      end
      DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = EMIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      EMIT: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIVIDE) |-> (sts_i.busy && !sts_i.span_zero))
    else $error("divide running without an active line");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OP_LOAD) |=> sts_i.busy)
    else $error("load did not start a line");

  a_beat_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == EMIT))
    else $error("output beat raised outside emit");
`endif

endmodule

/* rtl/lri_datapath.sv */
`timescale 1ns / 1ps
module lri_datapath import lri_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  draw_color_we_i,
  input  logic [31:0]           draw_color_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  lri_cmd_t              cmd_i,
  output lri_sts_t              sts_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [31:0]           pixel_color_o,
  output logic                  last_pixel_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned C2 = 2 * COORD_BITS;

  logic [31:0]   color_q;
  logic [C-1:0]  major_cur_q, major_first_q, major_final_q;
  logic [C-1:0]  minor_first_q, minor_final_q;
  logic          steep_q, busy_q;
  logic [C2-1:0] prod_q;
  logic [C-1:0]  rem_q, quo_q;
  logic [C-1:0]  px_q, py_q;
  logic [31:0]   pcolor_q;
  logic          plast_q;

  logic [C-1:0]  dx, dy, ma, na, mb, nb;
  logic          steep;
  logic [C-1:0]  span, off;
  logic [C2-1:0] prod_hi, num;
  logic [C:0]    trial, trial_sub;
  logic          qbit;
  logic [C-1:0]  minor;
  logic          last;

  assign dx    = (x_start_i > x_end_i) ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
  assign dy    = (y_start_i > y_end_i) ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
  assign steep = dx < dy;
  assign ma    = steep ? y_start_i : x_start_i;
  assign na    = steep ? x_start_i : y_start_i;
  assign mb    = steep ? y_end_i   : x_end_i;
  assign nb    = steep ? x_end_i   : y_end_i;

  assign span    = major_final_q - major_first_q;
  assign off     = major_cur_q - major_first_q;
  assign prod_hi = C2'(minor_final_q) * C2'(off);
  assign num     = prod_q + prod_hi;

  // restoring divide, one quotient bit per cycle
  assign trial     = {rem_q, quo_q[C-1]};
  assign trial_sub = trial - {1'b0, span};
  assign qbit      = trial >= {1'b0, span};

  assign minor = sts_o.span_zero ? minor_first_q : quo_q;
  assign last  = major_cur_q == major_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q       <= '0;
      major_cur_q   <= '0;
      major_first_q <= '0;
      major_final_q <= '0;
      minor_first_q <= '0;
      minor_final_q <= '0;
      steep_q       <= 1'b0;
      busy_q        <= 1'b0;
    end else begin
      if (draw_color_we_i) begin
        color_q <= draw_color_i;
      end
      if (cmd_i.load) begin
        steep_q <= steep;
        busy_q  <= 1'b1;
        if (ma > mb) begin
          major_first_q <= mb;
          minor_first_q <= nb;
          major_final_q <= ma;
          minor_final_q <= na;
          major_cur_q   <= mb;
        end else begin
          major_first_q <= ma;
          minor_first_q <= na;
          major_final_q <= mb;
          minor_final_q <= nb;
          major_cur_q   <= ma;
        end
      end else if (cmd_i.emit) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          major_cur_q <= major_cur_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      prod_q <= C2'(minor_first_q) * C2'(span - off);
    end
    if (cmd_i.mul_hi) begin
      rem_q <= num[C2-1:C];
      quo_q <= num[C-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? trial_sub[C-1:0] : trial[C-1:0];
      quo_q <= {quo_q[C-2:0], qbit};
    end
    if (cmd_i.emit) begin
      px_q     <= steep_q ? minor : major_cur_q;
      py_q     <= steep_q ? major_cur_q : minor;
      pcolor_q <= color_q;
      plast_q  <= last;
    end
  end

  assign sts_o.busy      = busy_q;
  assign sts_o.span_zero = span == '0;

  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcolor_q;
  assign last_pixel_o  = plast_q;

`ifndef ASSERT_OFF
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (major_cur_q >= major_first_q && major_cur_q <= major_final_q))
    else $error("major coordinate left the line span");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (major_first_q <= major_final_q))
    else $error("endpoints not ordered along major axis");
`endif

endmodule

/* rtl/line_rasterizer_interp.sv */
// Load beat: latches the endpoints and starts the line; no output beat.
// Step beat on an active line: MUL_LO, MUL_HI, DIVIDE, EMIT in order, DIVIDE
// being the radix-2 restoring divider, one quotient bit per cycle; a zero-span
// line goes straight to EMIT. The next beat is taken only back in IDLE.
// Emit waits while the output register holds an untaken beat.
// Async active-low reset clears line state, draw color and output valid.
`timescale 1ns / 1ps
module line_rasterizer_interp import lri_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  draw_color_we_i,
  input  logic [31:0]           draw_color_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [31:0]           pixel_color_o,
  output logic                  last_pixel_o
);

  lri_cmd_t cmd;
  lri_sts_t sts;

  lri_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lri_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .draw_color_we_i (draw_color_we_i),
    .draw_color_i    (draw_color_i),
    .x_start_i       (x_start_i),
    .y_start_i       (y_start_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_color_o   (pixel_color_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule
